// ===== hdl/hbs_pkg.sv =====
// Shared types and codes for the H-bridge supervisor.
// Used by hbridge_supervisor_fsm_unit; no dependencies.
`default_nettype none

package hbs_pkg;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		S_ST_START   = 9'b0_0000_0001,
		S_ST_RUN     = 9'b0_0000_0010,
		S_INIT_START = 9'b0_0000_0100,
		S_INIT_RUN   = 9'b0_0000_1000,
		S_CHECK      = 9'b0_0001_0000,
		S_ENABLE     = 9'b0_0010_0000,
		S_DISABLE    = 9'b0_0100_0000,
		S_TRISTATE   = 9'b0_1000_0000,
		S_FAILURE    = 9'b1_0000_0000
	} hbs_state_t;

	// Reported state codes
	localparam logic [3:0] CODE_ST_START   = 4'd0;
	localparam logic [3:0] CODE_ST_RUN     = 4'd1;
	localparam logic [3:0] CODE_INIT_START = 4'd2;
	localparam logic [3:0] CODE_INIT_RUN   = 4'd3;
	localparam logic [3:0] CODE_CHECK      = 4'd4;
	localparam logic [3:0] CODE_ENABLE     = 4'd5;
	localparam logic [3:0] CODE_DISABLE    = 4'd6;
	localparam logic [3:0] CODE_TRISTATE   = 4'd7;
	localparam logic [3:0] CODE_FAILURE    = 4'd8;

	// Requested SPI sequences
	localparam logic [2:0] SEQ_NONE     = 3'd0;
	localparam logic [2:0] SEQ_SELFTEST = 3'd1;
	localparam logic [2:0] SEQ_INIT_ALL = 3'd2;
	localparam logic [2:0] SEQ_CHECK    = 3'd3;
	localparam logic [2:0] SEQ_ONDIAG1  = 3'd4;
	localparam logic [2:0] SEQ_ONDIAG2  = 3'd5;
	localparam logic [2:0] SEQ_OFFSTATE = 3'd6;
	localparam logic [2:0] SEQ_OFFDIAG  = 3'd7;

	// Self-test status codes
	localparam logic [2:0] STT_RUNNING = 3'd0;
	localparam logic [2:0] STT_OK      = 3'd1;
	localparam logic [2:0] STT_SPI_ERR = 3'd2;

	// Register sequence status codes
	localparam logic [1:0] SEQST_DONE = 2'd1;
	localparam logic [1:0] SEQST_FAIL = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_HOLD_TICKS  = 2'd0;
	localparam logic [1:0] CFG_INIT_RETRY  = 2'd1;
	localparam logic [1:0] CFG_CHECK_RETRY = 2'd2;

	// Register reset values
	localparam logic [7:0] HOLD_TICKS_RST  = 8'd10;
	localparam logic [3:0] INIT_RETRY_RST  = 4'd3;
	localparam logic [3:0] CHECK_RETRY_RST = 4'd3;

	// Fault flag bit positions
	localparam int FF_SUPPLY   = 0;
	localparam int FF_ILIM     = 1;
	localparam int FF_NGFAIL   = 2;
	localparam int FF_HWSC_ND  = 3;
	localparam int FF_BDIS     = 4;
	localparam int FF_OT       = 5;
	localparam int FF_OL_LAST  = 6;
	localparam int FF_OL_DONE  = 7;
	localparam int FF_OFF_OC   = 8;
	localparam int FF_OFF_OL   = 9;
	localparam int FF_OC       = 10;
	localparam int FF_OVERLOAD = 11;

	function automatic logic [3:0] state_code(input hbs_state_t s);
		logic [3:0] c;
		unique case (s)
			S_ST_START:   c = CODE_ST_START;
			S_ST_RUN:     c = CODE_ST_RUN;
			S_INIT_START: c = CODE_INIT_START;
			S_INIT_RUN:   c = CODE_INIT_RUN;
			S_CHECK:      c = CODE_CHECK;
			S_ENABLE:     c = CODE_ENABLE;
			S_DISABLE:    c = CODE_DISABLE;
			S_TRISTATE:   c = CODE_TRISTATE;
			default:      c = CODE_FAILURE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hbridge_supervisor_fsm_unit.sv =====
// H-bridge supervisor: one sequencer step per tick item.
// Depends on hbs_pkg for state encoding and codes.
//
// Usage:
//   Each item on the input channel (in_valid/in_ready) is one supervision
//   tick carrying the decoded diagnostic flags and sequence statuses. Each
//   tick yields exactly one result item on the output channel
//   (out_valid/out_ready): state, disable pin, drive flag, requested SPI
//   sequence and diagnostic masks.
//   The item is captured in an input register; the step logic is
//   combinational and writes the result register once that register is free.
//   One item per cycle is sustained while the receiver takes every result.
//   A stalled receiver holds the result register; the input register still
//   takes one more item, after which in_ready drops until out_ready frees
//   the result register.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; writes are meant for idle periods. Index 0 is the tristate hold
//   time, 1 the init retry limit, 2 the check retry limit; others drop.
//   Reset starts in self-test with the disable pin high and drive off, and
//   the registers at their defaults; no clearing pass is needed.
`default_nettype none

module hbridge_supervisor_fsm_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// tick input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        on_diag_ready,
	input  wire logic        off_diag_ready,
	input  wire logic [2:0]  fresh_reads,
	input  wire logic [11:0] fault_flags,
	input  wire logic [2:0]  selftest_status,
	input  wire logic [1:0]  init_status,
	input  wire logic [1:0]  readback_status,
	input  wire logic        config_matches,
	input  wire logic        enable_request,
	input  wire logic        spi_fault,
	// result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       bridge_state,
	output logic             disable_pin_high,
	output logic             drive_enabled,
	output logic [2:0]       sequence_request,
	output logic             diag_report_valid,
	output logic [3:0]       ecu_valid_mask,
	output logic [3:0]       ecu_fault_mask,
	output logic [3:0]       actuator_valid_mask,
	output logic [3:0]       actuator_fault_mask,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	// Configuration registers
	logic [7:0] hold_ticks_q;
	logic [3:0] init_limit_q;
	logic [3:0] check_limit_q;

	// Supervisor state
	hbs_pkg::hbs_state_t state_q;
	logic [3:0] init_left_q;
	logic [3:0] check_left_q;
	logic [7:0] tri_timer_q;
	logic       leave_ok_q;
	logic       st_passed_q;
	logic       pin_q;
	logic       drive_q;

	// Input register
	logic        valid_s1;
	logic        on_rdy_s1;
	logic        off_rdy_s1;
	logic [2:0]  fresh_s1;
	logic [11:0] ff_s1;
	logic [2:0]  st_stat_s1;
	logic [1:0]  ini_s1;
	logic [1:0]  rdb_s1;
	logic        match_s1;
	logic        en_req_s1;
	logic        spi_err_s1;

	// Result register
	logic       out_valid_q;
	logic [3:0] state_code_q;
	logic       pin_out_q;
	logic       drive_out_q;
	logic [2:0] seq_q;
	logic       report_q;
	logic [3:0] ev_q;
	logic [3:0] ef_q;
	logic [3:0] av_q;
	logic [3:0] af_q;

	// Next-step values
	hbs_pkg::hbs_state_t n_state;
	logic [3:0] n_init_left;
	logic [3:0] n_check_left;
	logic [7:0] n_timer;
	logic       n_leave_ok;
	logic       n_st_passed;
	logic       n_pin;
	logic       n_drive;
	logic [2:0] n_seq;
	logic       n_report;
	logic [3:0] n_ev;
	logic [3:0] n_ef;
	logic [3:0] n_av;
	logic [3:0] n_af;

	logic advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q  <= hbs_pkg::HOLD_TICKS_RST;
			init_limit_q  <= hbs_pkg::INIT_RETRY_RST;
			check_limit_q <= hbs_pkg::CHECK_RETRY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hbs_pkg::CFG_HOLD_TICKS:  hold_ticks_q  <= cfg_data;
				hbs_pkg::CFG_INIT_RETRY:  init_limit_q  <= cfg_data[3:0];
				hbs_pkg::CFG_CHECK_RETRY: check_limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			on_rdy_s1  <= on_diag_ready;
			off_rdy_s1 <= off_diag_ready;
			fresh_s1   <= fresh_reads;
			ff_s1      <= fault_flags;
			st_stat_s1 <= selftest_status;
			ini_s1     <= init_status;
			rdb_s1     <= readback_status;
			match_s1   <= config_matches;
			en_req_s1  <= enable_request;
			spi_err_s1 <= spi_fault;
		end
	end

	// One supervision step
	always_comb begin
		logic to_tri;
		logic new2;

		n_state      = state_q;
		n_init_left  = init_left_q;
		n_check_left = check_left_q;
		n_timer      = tri_timer_q;
		n_leave_ok   = leave_ok_q;
		n_st_passed  = st_passed_q;
		n_pin        = pin_q;
		n_drive      = drive_q;
		n_seq        = hbs_pkg::SEQ_NONE;
		n_ev         = 4'd0;
		n_ef         = 4'd0;
		n_av         = 4'd0;
		n_af         = 4'd0;
		to_tri       = 1'b0;
		new2         = fresh_s1[0];
		n_report     = on_rdy_s1 || off_rdy_s1;

		// hold timer; release on reaching zero
		if (n_timer != 8'd0) begin
			n_timer = n_timer - 8'd1;
			if (n_timer == 8'd0)
				n_leave_ok = 1'b1;
		end

		if (n_report) begin
			n_ev[1:0] = 2'b11;
			n_ef[0]   = ff_s1[hbs_pkg::FF_SUPPLY];
			n_ef[1]   = ff_s1[hbs_pkg::FF_ILIM];
			if (on_rdy_s1 && !ff_s1[hbs_pkg::FF_NGFAIL]) begin
				n_av[1:0] = 2'b11;
				if (!new2)
					n_av[3:2] = 2'b11;
			end
			// chip reset detected: back to self-test
			if (ff_s1[hbs_pkg::FF_HWSC_ND] && ff_s1[hbs_pkg::FF_BDIS] &&
			    ff_s1[hbs_pkg::FF_NGFAIL]) begin
				n_ev[2] = 1'b1;
				n_ef[2] = 1'b1;
				n_pin   = 1'b1;
				n_drive = 1'b0;
				n_state = hbs_pkg::S_ST_START;
			end
			if (new2) begin
				n_av[2] = 1'b1;
				if (ff_s1[hbs_pkg::FF_OT]) begin
					n_af[2] = 1'b1;
					if (on_rdy_s1 && ff_s1[hbs_pkg::FF_NGFAIL])
						to_tri = 1'b1;
				end
				if (ff_s1[hbs_pkg::FF_OL_DONE]) begin
					n_av[3] = 1'b1;
					if (ff_s1[hbs_pkg::FF_OL_LAST])
						n_af[3] = 1'b1;
				end
			end
			if (fresh_s1[2]) begin
				n_av[0] = 1'b1;
				n_av[3] = 1'b1;
				if (ff_s1[hbs_pkg::FF_OFF_OC])
					n_af[0] = 1'b1;
				if (ff_s1[hbs_pkg::FF_OFF_OL])
					n_af[3] = 1'b1;
			end
			if (fresh_s1[1]) begin
				n_av[1:0] = 2'b11;
				if (ff_s1[hbs_pkg::FF_OC]) begin
					n_af[0] = 1'b1;
					to_tri  = 1'b1;
				end
				if (ff_s1[hbs_pkg::FF_OVERLOAD]) begin
					n_af[1] = 1'b1;
					to_tri  = 1'b1;
				end
			end
			// tristate wins over chip reset
			if (to_tri) begin
				n_pin      = 1'b1;
				n_drive    = 1'b0;
				n_timer    = hold_ticks_q;
				n_leave_ok = 1'b0;
				n_state    = hbs_pkg::S_TRISTATE;
			end
		end

		n_ev[3] = 1'b1;
		n_ef[3] = spi_err_s1;

		unique case (n_state)
			hbs_pkg::S_ST_START: begin
				n_seq   = hbs_pkg::SEQ_SELFTEST;
				n_state = hbs_pkg::S_ST_RUN;
			end
			hbs_pkg::S_ST_RUN: begin
				if (st_stat_s1 == hbs_pkg::STT_RUNNING) begin
					n_state = hbs_pkg::S_ST_RUN;
				end else if (st_stat_s1 == hbs_pkg::STT_OK) begin
					n_state     = hbs_pkg::S_INIT_START;
					n_st_passed = 1'b1;
				end else if (st_stat_s1 == hbs_pkg::STT_SPI_ERR) begin
					n_state = hbs_pkg::S_ST_START;
				end else begin
					// failed or unknown code
					n_state     = hbs_pkg::S_FAILURE;
					n_st_passed = 1'b0;
					n_pin       = 1'b1;
					n_drive     = 1'b0;
				end
			end
			hbs_pkg::S_INIT_START: begin
				if (n_init_left != 4'd0) begin
					n_seq   = hbs_pkg::SEQ_INIT_ALL;
					n_state = hbs_pkg::S_INIT_RUN;
				end else begin
					n_state = hbs_pkg::S_FAILURE;
					n_pin   = 1'b1;
				end
			end
			hbs_pkg::S_INIT_RUN: begin
				if (ini_s1 == hbs_pkg::SEQST_DONE) begin
					n_check_left = check_limit_q;
					n_seq        = hbs_pkg::SEQ_CHECK;
					n_state      = hbs_pkg::S_CHECK;
				end else if (ini_s1 == hbs_pkg::SEQST_FAIL) begin
					if (n_init_left != 4'd0)
						n_init_left = n_init_left - 4'd1;
					if (n_init_left != 4'd0) begin
						n_seq   = hbs_pkg::SEQ_INIT_ALL;
						n_state = hbs_pkg::S_INIT_RUN;
					end else begin
						n_state = hbs_pkg::S_FAILURE;
						n_pin   = 1'b1;
					end
				end
			end
			hbs_pkg::S_CHECK: begin
				if (rdb_s1 == hbs_pkg::SEQST_DONE && match_s1) begin
					n_init_left = init_limit_q;
					if (en_req_s1) begin
						n_pin   = 1'b0;
						n_drive = 1'b1;
						n_state = hbs_pkg::S_ENABLE;
					end else begin
						n_state = hbs_pkg::S_DISABLE;
					end
				end else if (rdb_s1 == hbs_pkg::SEQST_DONE ||
				             rdb_s1 == hbs_pkg::SEQST_FAIL) begin
					// retry readback, else reinitialize
					if (n_check_left != 4'd0) begin
						n_check_left = n_check_left - 4'd1;
						n_seq        = hbs_pkg::SEQ_CHECK;
						n_state      = hbs_pkg::S_CHECK;
					end else begin
						if (n_init_left != 4'd0)
							n_init_left = n_init_left - 4'd1;
						if (n_init_left != 4'd0) begin
							n_seq   = hbs_pkg::SEQ_INIT_ALL;
							n_state = hbs_pkg::S_INIT_RUN;
						end else begin
							n_state = hbs_pkg::S_FAILURE;
							n_pin   = 1'b1;
						end
					end
				end
			end
			hbs_pkg::S_ENABLE: begin
				n_seq = ff_s1[hbs_pkg::FF_OL_LAST] ? hbs_pkg::SEQ_ONDIAG2
				                                   : hbs_pkg::SEQ_ONDIAG1;
			end
			hbs_pkg::S_DISABLE: begin
				n_seq = hbs_pkg::SEQ_OFFSTATE;
			end
			hbs_pkg::S_TRISTATE: begin
				n_seq = hbs_pkg::SEQ_OFFDIAG;
				if (n_leave_ok && !ff_s1[hbs_pkg::FF_OT] &&
				    !ff_s1[hbs_pkg::FF_OFF_OC]) begin
					if (en_req_s1) begin
						n_pin   = 1'b0;
						n_drive = 1'b1;
						n_state = hbs_pkg::S_ENABLE;
					end else begin
						n_state = hbs_pkg::S_DISABLE;
					end
				end
			end
			default: begin
				n_state = hbs_pkg::S_FAILURE;
				if (!n_st_passed) begin
					n_ev[2] = 1'b1;
					n_ef[2] = 1'b1;
				end
			end
		endcase
	end

	// State update, once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hbs_pkg::S_ST_START;
			init_left_q  <= hbs_pkg::INIT_RETRY_RST;
			check_left_q <= 4'd0;
			tri_timer_q  <= 8'd0;
			leave_ok_q   <= 1'b0;
			st_passed_q  <= 1'b0;
			pin_q        <= 1'b1;
			drive_q      <= 1'b0;
		end else if (advance) begin
			state_q      <= n_state;
			init_left_q  <= n_init_left;
			check_left_q <= n_check_left;
			tri_timer_q  <= n_timer;
			leave_ok_q   <= n_leave_ok;
			st_passed_q  <= n_st_passed;
			pin_q        <= n_pin;
			drive_q      <= n_drive;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_code_q <= hbs_pkg::state_code(n_state);
			pin_out_q    <= n_pin;
			drive_out_q  <= n_drive;
			seq_q        <= n_seq;
			report_q     <= n_report;
			ev_q         <= n_ev;
			ef_q         <= n_ef;
			av_q         <= n_av;
			af_q         <= n_af;
		end
	end

	assign out_valid           = out_valid_q;
	assign bridge_state        = state_code_q;
	assign disable_pin_high    = pin_out_q;
	assign drive_enabled       = drive_out_q;
	assign sequence_request    = seq_q;
	assign diag_report_valid   = report_q;
	assign ecu_valid_mask      = ev_q;
	assign ecu_fault_mask      = ef_q;
	assign actuator_valid_mask = av_q;
	assign actuator_fault_mask = af_q;

endmodule

`default_nettype wire

// ===== test/hbridge_supervisor_fsm_unit_tb.sv =====
// Testbench for hbridge_supervisor_fsm_unit: sends supervision ticks, predicts each
// result with its own model of the sequencer and checks every result item field by field.
// Depends on hbs_pkg and the unit under test only.
`timescale 1ns / 100ps

module hbridge_supervisor_fsm_unit_tb;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 12;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 10;
	localparam int PHASE_TICKS    = 310;
	localparam int NUM_PHASES     = 6;
	localparam int MAX_REPORTS    = 10;

	localparam logic [2:0] STT_FAILED  = 3'd3;
	localparam logic [2:0] STT_UNKNOWN = 3'd4;
	localparam logic [1:0] SEQST_BUSY   = 2'd0;
	localparam logic [1:0] SEQST_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED   = 2'd3;

	localparam logic [11:0] CHIP_RESET_FLAGS = (12'd1 << hbs_pkg::FF_HWSC_ND) |
		(12'd1 << hbs_pkg::FF_BDIS) | (12'd1 << hbs_pkg::FF_NGFAIL);

	typedef struct packed {
		logic        on_rdy;
		logic        off_rdy;
		logic [2:0]  fresh;
		logic [11:0] flags;
		logic [2:0]  selftest;
		logic [1:0]  init_st;
		logic [1:0]  readback;
		logic        regs_match;
		logic        en_req;
		logic        spi_err;
	} tick_t;

	typedef struct packed {
		logic [3:0] state;
		logic       pin;
		logic       drive;
		logic [2:0] seq;
		logic       report;
		logic [3:0] ecu_v;
		logic [3:0] ecu_f;
		logic [3:0] act_v;
		logic [3:0] act_f;
	} supervisor_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        on_diag_ready = 1'b0;
	logic        off_diag_ready = 1'b0;
	logic [2:0]  fresh_reads = '0;
	logic [11:0] fault_flags = '0;
	logic [2:0]  selftest_status = '0;
	logic [1:0]  init_status = '0;
	logic [1:0]  readback_status = '0;
	logic        config_matches = 1'b0;
	logic        enable_request = 1'b0;
	logic        spi_fault = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  bridge_state;
	logic        disable_pin_high;
	logic        drive_enabled;
	logic [2:0]  sequence_request;
	logic        diag_report_valid;
	logic [3:0]  ecu_valid_mask;
	logic [3:0]  ecu_fault_mask;
	logic [3:0]  actuator_valid_mask;
	logic [3:0]  actuator_fault_mask;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// predicted supervisor state and register copies
	logic [3:0] sv_state = hbs_pkg::CODE_ST_START;
	logic [3:0] sv_init_left = hbs_pkg::INIT_RETRY_RST;
	logic [3:0] sv_check_left = '0;
	logic [7:0] sv_timer = '0;
	logic       sv_release = 1'b0;
	logic       sv_st_passed = 1'b0;
	logic       sv_pin = 1'b1;
	logic       sv_drive = 1'b0;
	logic [2:0] sv_seq = hbs_pkg::SEQ_NONE;
	logic [7:0] hold_cfg = hbs_pkg::HOLD_TICKS_RST;
	logic [3:0] init_limit_cfg = hbs_pkg::INIT_RETRY_RST;
	logic [3:0] check_limit_cfg = hbs_pkg::CHECK_RETRY_RST;

	supervisor_out_t pending_outputs[$];
	int ticks_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int holdoff_requests = 0;
	int holdoff_served = 0;
	int holdoff_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;

	hbridge_supervisor_fsm_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.on_diag_ready(on_diag_ready), .off_diag_ready(off_diag_ready),
		.fresh_reads(fresh_reads), .fault_flags(fault_flags),
		.selftest_status(selftest_status), .init_status(init_status),
		.readback_status(readback_status), .config_matches(config_matches),
		.enable_request(enable_request), .spi_fault(spi_fault),
		.out_valid(out_valid), .out_ready(out_ready),
		.bridge_state(bridge_state), .disable_pin_high(disable_pin_high),
		.drive_enabled(drive_enabled), .sequence_request(sequence_request),
		.diag_report_valid(diag_report_valid),
		.ecu_valid_mask(ecu_valid_mask), .ecu_fault_mask(ecu_fault_mask),
		.actuator_valid_mask(actuator_valid_mask),
		.actuator_fault_mask(actuator_fault_mask),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// ---------------- supervisor prediction ----------------

	function automatic void enter_init();
		if (sv_init_left != 0) begin
			sv_seq = hbs_pkg::SEQ_INIT_ALL;
			sv_state = hbs_pkg::CODE_INIT_RUN;
		end else begin
			sv_state = hbs_pkg::CODE_FAILURE;
			sv_pin = 1'b1;
		end
	endfunction

	function automatic void retry_check();
		if (sv_check_left != 0) begin
			sv_check_left = sv_check_left - 4'd1;
			sv_seq = hbs_pkg::SEQ_CHECK;
			sv_state = hbs_pkg::CODE_CHECK;
		end else begin
			if (sv_init_left != 0)
				sv_init_left = sv_init_left - 4'd1;
			enter_init();
		end
	endfunction

	function automatic void release_bridge(input logic en_req);
		if (en_req) begin
			sv_pin = 1'b0;
			sv_drive = 1'b1;
			sv_state = hbs_pkg::CODE_ENABLE;
		end else begin
			sv_state = hbs_pkg::CODE_DISABLE;
		end
	endfunction

	function automatic supervisor_out_t step_supervisor(input tick_t t);
		supervisor_out_t r;
		logic [3:0] ev, ef, av, af;
		logic report, new2, to_tri;
		ev = '0;
		ef = '0;
		av = '0;
		af = '0;
		to_tri = 1'b0;
		report = t.on_rdy || t.off_rdy;
		new2 = t.fresh[0];
		sv_seq = hbs_pkg::SEQ_NONE;

		if (sv_timer != 0) begin
			sv_timer = sv_timer - 8'd1;
			if (sv_timer == 0)
				sv_release = 1'b1;
		end

		if (report) begin
			ev = 4'h3;
			ef[0] = t.flags[hbs_pkg::FF_SUPPLY];
			ef[1] = t.flags[hbs_pkg::FF_ILIM];
			if (t.on_rdy && !t.flags[hbs_pkg::FF_NGFAIL]) begin
				av |= 4'h3;
				if (!new2)
					av |= 4'hC;
			end
			// chip lost its registers: back to self-test
			if (t.flags[hbs_pkg::FF_HWSC_ND] && t.flags[hbs_pkg::FF_BDIS] &&
			    t.flags[hbs_pkg::FF_NGFAIL]) begin
				ev |= 4'h4;
				ef |= 4'h4;
				sv_pin = 1'b1;
				sv_drive = 1'b0;
				sv_state = hbs_pkg::CODE_ST_START;
			end
			if (new2) begin
				av |= 4'h4;
				if (t.flags[hbs_pkg::FF_OT]) begin
					af |= 4'h4;
					if (t.on_rdy && t.flags[hbs_pkg::FF_NGFAIL])
						to_tri = 1'b1;
				end
				if (t.flags[hbs_pkg::FF_OL_DONE]) begin
					av |= 4'h8;
					if (t.flags[hbs_pkg::FF_OL_LAST])
						af |= 4'h8;
				end
			end
			if (t.fresh[2]) begin
				av |= 4'h9;
				if (t.flags[hbs_pkg::FF_OFF_OC])
					af |= 4'h1;
				if (t.flags[hbs_pkg::FF_OFF_OL])
					af |= 4'h8;
			end
			if (t.fresh[1]) begin
				av |= 4'h3;
				if (t.flags[hbs_pkg::FF_OC]) begin
					af |= 4'h1;
					to_tri = 1'b1;
				end
				if (t.flags[hbs_pkg::FF_OVERLOAD]) begin
					af |= 4'h2;
					to_tri = 1'b1;
				end
			end
			if (to_tri) begin
				sv_pin = 1'b1;
				sv_drive = 1'b0;
				sv_timer = hold_cfg;
				sv_release = 1'b0;
				sv_state = hbs_pkg::CODE_TRISTATE;
			end
		end

		ev |= 4'h8;
		if (t.spi_err)
			ef |= 4'h8;

		case (sv_state)
			hbs_pkg::CODE_ST_START: begin
				sv_seq = hbs_pkg::SEQ_SELFTEST;
				sv_state = hbs_pkg::CODE_ST_RUN;
			end
			hbs_pkg::CODE_ST_RUN: begin
				if (t.selftest == hbs_pkg::STT_OK) begin
					sv_state = hbs_pkg::CODE_INIT_START;
					sv_st_passed = 1'b1;
				end else if (t.selftest == hbs_pkg::STT_SPI_ERR) begin
					sv_state = hbs_pkg::CODE_ST_START;
				end else if (t.selftest != hbs_pkg::STT_RUNNING) begin
					sv_state = hbs_pkg::CODE_FAILURE;
					sv_st_passed = 1'b0;
					sv_pin = 1'b1;
					sv_drive = 1'b0;
				end
			end
			hbs_pkg::CODE_INIT_START: enter_init();
			hbs_pkg::CODE_INIT_RUN: begin
				if (t.init_st == hbs_pkg::SEQST_DONE) begin
					sv_check_left = check_limit_cfg;
					sv_seq = hbs_pkg::SEQ_CHECK;
					sv_state = hbs_pkg::CODE_CHECK;
				end else if (t.init_st == hbs_pkg::SEQST_FAIL) begin
					if (sv_init_left != 0)
						sv_init_left = sv_init_left - 4'd1;
					enter_init();
				end
			end
			hbs_pkg::CODE_CHECK: begin
				if (t.readback == hbs_pkg::SEQST_DONE) begin
					if (t.regs_match) begin
						sv_init_left = init_limit_cfg;
						release_bridge(t.en_req);
					end else begin
						retry_check();
					end
				end else if (t.readback == hbs_pkg::SEQST_FAIL) begin
					retry_check();
				end
			end
			hbs_pkg::CODE_ENABLE:
				sv_seq = t.flags[hbs_pkg::FF_OL_LAST] ? hbs_pkg::SEQ_ONDIAG2
				                                      : hbs_pkg::SEQ_ONDIAG1;
			hbs_pkg::CODE_DISABLE: sv_seq = hbs_pkg::SEQ_OFFSTATE;
			hbs_pkg::CODE_TRISTATE: begin
				sv_seq = hbs_pkg::SEQ_OFFDIAG;
				if (sv_release && !t.flags[hbs_pkg::FF_OT] &&
				    !t.flags[hbs_pkg::FF_OFF_OC])
					release_bridge(t.en_req);
			end
			default: begin
				sv_state = hbs_pkg::CODE_FAILURE;
				if (!sv_st_passed) begin
					ev |= 4'h4;
					ef |= 4'h4;
				end
			end
		endcase

		r.state = sv_state;
		r.pin = sv_pin;
		r.drive = sv_drive;
		r.seq = sv_seq;
		r.report = report;
		r.ecu_v = ev;
		r.ecu_f = ef;
		r.act_v = av;
		r.act_f = af;
		return r;
	endfunction

	function automatic string describe(input supervisor_out_t o);
		return $sformatf("state=%0d pin=%b drive=%b seq=%0d diag=%b ecu=%h/%h act=%h/%h",
			o.state, o.pin, o.drive, o.seq, o.report, o.ecu_v, o.ecu_f, o.act_v, o.act_f);
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic tick_t mk(input int on_rdy, input int off_rdy,
			input logic [2:0] fresh, input logic [11:0] flags,
			input logic [2:0] selftest, input logic [1:0] init_st,
			input logic [1:0] readback, input int regs_match,
			input int en_req, input int spi_err);
		tick_t t;
		t = {on_rdy != 0, off_rdy != 0, fresh, flags, selftest, init_st, readback,
			regs_match != 0, en_req != 0, spi_err != 0};
		return t;
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int r;
		t.on_rdy = ($urandom_range(0, 9) < 3);
		t.off_rdy = ($urandom_range(0, 9) < 3);
		t.fresh = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 3) == 0) begin
			t.flags = 12'($urandom_range(0, 4095));
		end else begin
			t.flags = '0;
			for (int b = 0; b < 12; b++)
				t.flags[b] = ($urandom_range(0, 9) == 0);
		end
		// failure is left via chip reset or tristate: offer a chip reset more often there
		if ($urandom_range(0, 99) < (sv_state == hbs_pkg::CODE_FAILURE ? 25 : 2)) begin
			t.on_rdy = 1'b1;
			t.flags |= CHIP_RESET_FLAGS;
		end
		r = $urandom_range(0, 99);
		t.selftest = (r < 55) ? hbs_pkg::STT_OK : (r < 75) ? hbs_pkg::STT_RUNNING :
			(r < 87) ? hbs_pkg::STT_SPI_ERR : (r < 94) ? STT_FAILED : STT_UNKNOWN;
		r = $urandom_range(0, 99);
		t.init_st = (r < 65) ? hbs_pkg::SEQST_DONE : (r < 80) ? SEQST_BUSY :
			(r < 95) ? hbs_pkg::SEQST_FAIL : SEQST_UNUSED;
		r = $urandom_range(0, 99);
		t.readback = (r < 65) ? hbs_pkg::SEQST_DONE : (r < 80) ? SEQST_BUSY :
			(r < 95) ? hbs_pkg::SEQST_FAIL : SEQST_UNUSED;
		t.regs_match = ($urandom_range(0, 99) < 85);
		t.en_req = ($urandom_range(0, 99) < 70);
		t.spi_err = ($urandom_range(0, 9) == 0);
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		@(negedge clk);
		in_valid <= 1'b1;
		on_diag_ready <= t.on_rdy;
		off_diag_ready <= t.off_rdy;
		fresh_reads <= t.fresh;
		fault_flags <= t.flags;
		selftest_status <= t.selftest;
		init_status <= t.init_st;
		readback_status <= t.readback;
		config_matches <= t.regs_match;
		enable_request <= t.en_req;
		spi_fault <= t.spi_err;
		do @(posedge clk); while (!in_ready);
		pending_outputs.push_back(step_supervisor(t));
		ticks_sent++;
	endtask

	task automatic idle_sender(input int cycles);
		repeat (cycles) @(negedge clk) in_valid <= 1'b0;
	endtask

	// drop valid and hold until every result has come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hbs_pkg::CFG_HOLD_TICKS:  hold_cfg = data;
			hbs_pkg::CFG_INIT_RETRY:  init_limit_cfg = data[3:0];
			hbs_pkg::CFG_CHECK_RETRY: check_limit_cfg = data[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ---------------- receiver and checker ----------------

	always @(negedge clk) begin
		if (holdoff_served != holdoff_requests) begin
			holdoff_left = HOLDOFF_CYCLES;
			holdoff_served++;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(10, 150);
			end
			rx_mode_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 4) < 2);
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		supervisor_out_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {bridge_state, disable_pin_high, drive_enabled, sequence_request,
				diag_report_valid, ecu_valid_mask, ecu_fault_mask,
				actuator_valid_mask, actuator_fault_mask};
			if (pending_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result with no tick pending: %s", describe(got));
			end else begin
				want = pending_outputs.pop_front();
				results_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d mismatch\n  expected %s\n  actual   %s",
							results_checked, describe(want), describe(got));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_outputs.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------- tests ----------------

	// self-test, register init and readback with their retries, up to enable
	task automatic test_bringup();
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_RUNNING,
			SEQST_BUSY, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_RUNNING,
			SEQST_BUSY, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_SPI_ERR,
			SEQST_BUSY, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_RUNNING,
			SEQST_BUSY, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			SEQST_BUSY, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			SEQST_BUSY, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			SEQST_UNUSED, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_FAIL, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, SEQST_BUSY, 0, 0, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 0, 1, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_FAIL, 1, 1, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, SEQST_UNUSED, 1, 1, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 1));
	endtask

	// diagnostic masks, forced tristate, chip reset and failed self-test
	task automatic test_fault_handling();
		// no diagnostics ready: everything but open-load-last is ignored
		send_tick(mk(0, 0, 3'd7, 12'hFFF, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		send_tick(mk(0, 1, 3'd4, (12'd1 << hbs_pkg::FF_OFF_OC) | (12'd1 << hbs_pkg::FF_OFF_OL),
			hbs_pkg::STT_OK, hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		// over-temperature during on-diagnostics
		send_tick(mk(1, 0, 3'd1, (12'd1 << hbs_pkg::FF_NGFAIL) | (12'd1 << hbs_pkg::FF_OT),
			hbs_pkg::STT_OK, hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		// chip reset together with over-current: tristate wins
		send_tick(mk(1, 1, 3'd3, 12'hFFF, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 1));
		send_tick(mk(1, 0, 3'd0, CHIP_RESET_FLAGS, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, STT_UNKNOWN,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		send_tick(mk(1, 0, 3'd0, CHIP_RESET_FLAGS, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, STT_FAILED,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
	endtask

	// zero hold time: tristate is left only through a chip reset
	task automatic test_zero_hold();
		wait_idle();
		write_reg(hbs_pkg::CFG_HOLD_TICKS, 8'd0);
		settings_used++;
		send_tick(mk(1, 0, 3'd2, CHIP_RESET_FLAGS | (12'd1 << hbs_pkg::FF_OC),
			hbs_pkg::STT_OK, hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		send_tick(mk(0, 0, 3'd0, 12'h000, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
		send_tick(mk(1, 0, 3'd0, CHIP_RESET_FLAGS, hbs_pkg::STT_OK,
			hbs_pkg::SEQST_DONE, hbs_pkg::SEQST_DONE, 1, 1, 0));
	endtask

	task automatic run_random_phase(input int n_ticks, input bit with_holdoff,
			input bit with_pause);
		int burst_left;
		burst_left = 0;
		for (int i = 0; i < n_ticks; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					idle_sender($urandom_range(1, 8));
			end
			// receiver stops while ticks keep coming: input side must stall
			if (with_holdoff && i == n_ticks / 3)
				holdoff_requests++;
			if (with_pause && i == n_ticks / 2)
				wait_idle();
			send_tick(random_tick());
			burst_left--;
		end
	endtask

	task automatic test_random_settings();
		logic [7:0] hold;
		logic [3:0] init_lim, check_lim;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: {hold, init_lim, check_lim} = {8'd0, 4'd0, 4'd0};
				1: {hold, init_lim, check_lim} = {8'd255, 4'd15, 4'd15};
				2: {hold, init_lim, check_lim} = {8'd1, 4'd1, 4'd0};
				3: {hold, init_lim, check_lim} = {hbs_pkg::HOLD_TICKS_RST,
					hbs_pkg::INIT_RETRY_RST, hbs_pkg::CHECK_RETRY_RST};
				default: begin
					hold = 8'($urandom_range(0, 40));
					init_lim = 4'($urandom_range(0, 15));
					check_lim = 4'($urandom_range(0, 15));
				end
			endcase
			wait_idle();
			// upper data bits are don't-care for the 4-bit registers
			write_reg(hbs_pkg::CFG_HOLD_TICKS, hold);
			write_reg(hbs_pkg::CFG_INIT_RETRY, {4'($urandom_range(0, 15)), init_lim});
			write_reg(hbs_pkg::CFG_CHECK_RETRY, {4'($urandom_range(0, 15)), check_lim});
			if (phase == 2)
				write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
			settings_used++;
			run_random_phase(PHASE_TICKS, phase == 1, phase == 2);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		settings_used = 1;
		test_bringup();
		test_fault_handling();
		test_zero_hold();
		test_random_settings();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d ticks under %0d register settings, with stalls on both sides",
			ticks_sent, settings_used);
		$display("%0d results checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
